// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the project clock and reset names.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/dqs_pkg.sv =====
package dqs_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned NAME_BITS = 64;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned IdW     = 32;
  localparam int unsigned NameW   = 64;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW  = $clog2(DEPTH + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK           = 3'd0,
    STS_POP_EMPTY    = 3'd1,
    STS_SEARCH_EMPTY = 3'd2,
    STS_NOT_FOUND    = 3'd3,
    STS_FULL         = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;
    logic op_en;
    logic search_start;
    logic search_run;
    logic res_found;
    logic res_notfound;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic search_go;
    logic out_busy;
    logic cmp_valid;
    logic cmp_match;
    logic cmp_last;
  } ctrl_sts_t;

endpackage

// ===== design/dqs_if.sv =====
interface dqs_req_if;
  logic                          valid;
  logic                          ready;
  logic [dqs_pkg::CmdW-1:0]      cmd;
  logic [dqs_pkg::IdW-1:0]       action_id;
  logic [dqs_pkg::NameW-1:0]     action_name;
  logic [dqs_pkg::TimeW-1:0]     run_time;
  logic [dqs_pkg::TimeW-1:0]     used_time;

  modport source (output valid, cmd, action_id, action_name, run_time, used_time,
                  input ready);
  modport sink   (input valid, cmd, action_id, action_name, run_time, used_time,
                  output ready);
endinterface

interface dqs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dqs_pkg::StatusW-1:0]   status;
  logic [dqs_pkg::PosW-1:0]      position;
  logic [dqs_pkg::CountW-1:0]    count;

  modport source (output valid, status, position, count, input ready);
  modport sink   (input valid, status, position, count, output ready);
endinterface

// ===== design/dqs_ctrl.sv =====
module dqs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  dqs_pkg::ctrl_sts_t  sts_i,
  output dqs_pkg::ctrl_cmd_t  cmd_o
);

  dqs_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = (state_q == dqs_pkg::ST_IDLE) && !sts_i.out_busy && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dqs_pkg::ST_IDLE: begin
        if (accept && sts_i.search_go) state_d = dqs_pkg::ST_SEARCH;
      end
      dqs_pkg::ST_SEARCH: begin
        if (sts_i.cmp_valid && (sts_i.cmp_match || sts_i.cmp_last)) begin
          state_d = dqs_pkg::ST_IDLE;
        end
      end
      default: state_d = dqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      dqs_pkg::ST_IDLE: begin
        cmd_o.in_ready     = !sts_i.out_busy;
        cmd_o.op_en        = accept && !sts_i.search_go;
        cmd_o.search_start = accept && sts_i.search_go;
      end
      dqs_pkg::ST_SEARCH: begin
        cmd_o.search_run   = 1'b1;
        cmd_o.res_found    = sts_i.cmp_valid && sts_i.cmp_match;
        cmd_o.res_notfound = sts_i.cmp_valid && !sts_i.cmp_match && sts_i.cmp_last;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/dqs_dp.sv =====
module dqs_dp #(
  parameter int unsigned NAME_BITS = dqs_pkg::NAME_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dqs_pkg::ctrl_cmd_t            cmd_i,
  output dqs_pkg::ctrl_sts_t            sts_o,
  input  logic [dqs_pkg::CmdW-1:0]      in_cmd_i,
  input  logic [dqs_pkg::IdW-1:0]       in_id_i,
  input  logic [dqs_pkg::NameW-1:0]     in_name_i,
  input  logic [dqs_pkg::TimeW-1:0]     in_run_i,
  input  logic [dqs_pkg::TimeW-1:0]     in_used_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dqs_pkg::StatusW-1:0]   out_status_o,
  output logic [dqs_pkg::PosW-1:0]      out_position_o,
  output logic [dqs_pkg::CountW-1:0]    out_count_o
);

  localparam int unsigned DEPTH = dqs_pkg::DEPTH;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [dqs_pkg::IdW-1:0]   id;
    logic [NAME_BITS-1:0]      name;
    logic [dqs_pkg::TimeW-1:0] run_time;
    logic [dqs_pkg::TimeW-1:0] used_time;
  } rec_t;

  rec_t mem [DEPTH];

  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic [NAME_BITS-1:0]  key_q;
  logic [CW-1:0]         rd_off_q;
  logic [CW-1:0]         cmp_off_q;
  logic                  cmp_vld_q;
  rec_t                  rd_q;

  logic                  out_valid_q;
  dqs_pkg::status_e      out_status_q, op_status;
  logic [CW-1:0]         out_pos_q;
  logic [CW-1:0]         out_count_q;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  rec_t                  wr_rec;
  logic                  full, empty, issue;
  logic [AW-1:0]         front_dec;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign issue     = cmd_i.search_run && (rd_off_q < count_q);

  assign wr_rec.id        = in_id_i;
  assign wr_rec.name      = in_name_i[NAME_BITS-1:0];
  assign wr_rec.run_time  = in_run_i;
  assign wr_rec.used_time = in_used_i;

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    wr_addr   = front_dec;
    op_status = dqs_pkg::STS_OK;
    case (in_cmd_i)
      dqs_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          op_status = dqs_pkg::STS_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = front_dec;
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
      end
      dqs_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          op_status = dqs_pkg::STS_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = slot(front_q, count_q[AW-1:0]);
          count_d = count_q + CW'(1);
        end
      end
      dqs_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          op_status = dqs_pkg::STS_POP_EMPTY;
        end else begin
          front_d = slot(front_q, AW'(1));
          count_d = count_q - CW'(1);
        end
      end
      dqs_pkg::CMD_POP_BACK: begin
        if (empty) begin
          op_status = dqs_pkg::STS_POP_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      dqs_pkg::CMD_SEARCH: begin
        // A search on a non-empty queue goes through the scan instead.
        op_status = dqs_pkg::STS_SEARCH_EMPTY;
      end
      default: op_status = dqs_pkg::STS_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_en && wr_en) mem[wr_addr] <= wr_rec;
    rd_q <= mem[slot(front_q, rd_off_q[AW-1:0])];
    if (cmd_i.search_start) key_q <= in_name_i[NAME_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      rd_off_q  <= '0;
      cmp_off_q <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.op_en) begin
        front_q <= front_d;
        count_q <= count_d;
      end
      if (cmd_i.search_start) begin
        rd_off_q <= '0;
      end else if (issue) begin
        rd_off_q <= rd_off_q + CW'(1);
      end
      // Read data arrives in the cycle after the address, so the compare lags.
      cmp_vld_q <= issue && !cmd_i.res_found && !cmd_i.res_notfound;
      cmp_off_q <= rd_off_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op_en || cmd_i.res_found || cmd_i.res_notfound) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_en) begin
      out_status_q <= op_status;
      out_pos_q    <= '0;
      out_count_q  <= count_d;
    end else if (cmd_i.res_found) begin
      out_status_q <= dqs_pkg::STS_OK;
      out_pos_q    <= cmp_off_q;
      out_count_q  <= count_q;
    end else if (cmd_i.res_notfound) begin
      out_status_q <= dqs_pkg::STS_NOT_FOUND;
      out_pos_q    <= '0;
      out_count_q  <= count_q;
    end
  end

  assign sts_o.search_go = (in_cmd_i == dqs_pkg::CMD_SEARCH) && !empty;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.cmp_valid = cmp_vld_q;
  assign sts_o.cmp_match = (rd_q.name == key_q);
  assign sts_o.cmp_last  = (cmp_off_q == count_q - CW'(1));

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_position_o = dqs_pkg::PosW'(out_pos_q);
  assign out_count_o    = dqs_pkg::CountW'(out_count_q);

endmodule

// ===== design/double_ended_queue_with_search_unit.sv =====
// Bounded double-ended queue of action records held in a ring buffer.
// The request channel (req_i) carries one command per transaction: push at
// the front or back, pop from the front or back, or search by name. The
// response channel (rsp_o) returns exactly one transaction per command with
// a status, the match position for a successful search and the fill count
// after the command.
// Pushes, pops and searches on an empty queue complete in the accepting
// cycle; the response is registered and shows up in the cycle after. A search
// scans the stored names one per cycle through the registered read port of
// the record memory: each read name is compared against the registered key,
// the response to a match or to a miss at the last name is registered, and the
// request channel is held off while the scan runs.
// A new request is taken while the previous response is being taken, so
// pushes and pops sustain one per cycle. When the receiver stalls, the
// response holds and no new request is accepted until it is taken.
// Reset clears the front pointer, fill count, scan state and response valid;
// the record memory needs no clearing since only live slots are ever compared.
module double_ended_queue_with_search_unit #(
  parameter int unsigned NAME_BITS = dqs_pkg::NAME_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dqs_req_if.sink    req_i,
  dqs_rsp_if.source  rsp_o
);

  dqs_pkg::ctrl_cmd_t ctrl_cmd;
  dqs_pkg::ctrl_sts_t ctrl_sts;

  dqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  dqs_dp #(
    .NAME_BITS (NAME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .sts_o          (ctrl_sts),
    .in_cmd_i       (req_i.cmd),
    .in_id_i        (req_i.action_id),
    .in_name_i      (req_i.action_name),
    .in_run_i       (req_i.run_time),
    .in_used_i      (req_i.used_time),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .out_status_o   (rsp_o.status),
    .out_position_o (rsp_o.position),
    .out_count_o    (rsp_o.count)
  );

  assign req_i.ready = ctrl_cmd.in_ready;

endmodule

// ===== design/dqs_checker.sv =====
`include "assert_macros.svh"

module dqs_checker #(
  parameter int unsigned DEPTH = dqs_pkg::DEPTH
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [dqs_pkg::StatusW-1:0] rsp_status_i,
  input logic [dqs_pkg::PosW-1:0]    rsp_position_i,
  input logic [dqs_pkg::CountW-1:0]  rsp_count_i
);

  // A stalled response must hold its contents.
  `ASSERT_CLK(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_position_i) && $stable(rsp_count_i)), "stalled response changed")

  // No request is taken while a response waits untaken.
  `ASSERT_CLK(a_no_req_on_stall, (rsp_valid_i && !rsp_ready_i) |-> !req_ready_i, "request ready while response stalled")

  // The fill count never exceeds the capacity.
  `ASSERT_CLK(a_count_bound, rsp_valid_i |-> (rsp_count_i <= dqs_pkg::CountW'(DEPTH)), "count above capacity")

  // Only a successful search carries a nonzero position.
  `ASSERT_CLK(a_pos_zero, (rsp_valid_i && (rsp_status_i != dqs_pkg::STS_OK)) |-> (rsp_position_i == '0), "position set on failed command")

endmodule

bind double_ended_queue_with_search_unit dqs_checker u_dqs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_position_i (rsp_o.position),
  .rsp_count_i    (rsp_o.count)
);
